// ----- hdl/cfa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared types and codes of the contiguous fit allocator.
// ----------------------------------------------------------------------------
package cfa_pkg;

    localparam int DEF_MAX_EXTENTS = 16;
    localparam int DEF_ADDR_BITS   = 16;

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_FREE    = 2'd1;
    localparam logic [1:0] REQ_COMPACT = 2'd2;

    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_WORST = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOSPACE  = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_BADMODE  = 3'd3;
    localparam logic [2:0] ST_BADLEN   = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    localparam logic CFG_FIT_MODE = 1'b0;
    localparam logic CFG_CAPACITY = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [16:0] length;
        logic [15:0] address;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] start_address;
        logic [15:0] moved_from;
        logic        last;
    } t_rsp;

    // chain shift controls handed to every cell
    typedef struct packed {
        logic ins;      // open a hole at the pick point, write new extent
        logic del;      // close the hole at the pick point
        logic rot;      // rotate toward cell 0 (scan and compact walks)
    } t_shift;

endpackage
`default_nettype wire

// ----- hdl/cfa_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_cell
// One table slot: holds an extent and shifts with its neighbors.
// ----------------------------------------------------------------------------
module cfa_cell
    import cfa_pkg::*;
#(
    parameter int AW = DEF_ADDR_BITS
) (
    input  wire          i_clk,
    input  wire t_shift  i_ctl,
    input  wire          i_at_pick,   // this slot is the pick index
    input  wire          i_above,     // this slot is above the pick index
    input  wire [AW-1:0] i_new_first,
    input  wire [AW-1:0] i_new_final,
    input  wire [AW-1:0] i_lo_first,  // from lower neighbor
    input  wire [AW-1:0] i_lo_final,
    input  wire [AW-1:0] i_hi_first,  // from upper neighbor
    input  wire [AW-1:0] i_hi_final,
    output logic [AW-1:0] o_first,
    output logic [AW-1:0] o_final
);

    logic [AW-1:0] r_first, r_final;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && i_at_pick) begin
            r_first <= i_new_first;
            r_final <= i_new_final;
        end else if (i_ctl.ins && i_above) begin
            r_first <= i_lo_first;
            r_final <= i_lo_final;
        end else if ((i_ctl.del && (i_at_pick || i_above)) || i_ctl.rot) begin
            r_first <= i_hi_first;
            r_final <= i_hi_final;
        end
    end

    assign o_first = r_first;
    assign o_final = r_final;

endmodule
`default_nettype wire

// ----- hdl/contiguous_fit_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// contiguous_fit_allocator
// Extent table allocator with first, best and worst fit placement.
// ----------------------------------------------------------------------------
// Requests enter on i_req (valid/ready); results leave on o_rsp (valid/ready)
// from one output register. Config writes on i_cfg (index 0 fit mode,
// index 1 capacity) are taken at any time and are meant for idle periods.
// The extents sit in a chain of MAX_EXTENTS cells. Each request with a good
// early status walks the chain from cell 0 through a rotation: every cycle
// that the walk is not held, the whole chain rotates one place toward cell 0
// and the controller inspects cell 0. Allocate: one scan for the gap, an
// insert state, then the output state that loads the result. Free: one scan,
// a delete state and the same output state. Compact: one scan that rewrites
// each extent as it passes and emits one beat per extent (one beat for an
// empty table); the walk holds while the output register is full.
// One request is in work at a time; the next is taken once the walk is done
// and the output register is empty or its beat is leaving.
// Reset empties the table, mode first fit, capacity 65536; there is no
// clearing pass. A stalled receiver holds the walk on the current beat.
// ----------------------------------------------------------------------------
module contiguous_fit_allocator
    import cfa_pkg::*;
#(
    parameter int MAX_EXTENTS = DEF_MAX_EXTENTS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_req_valid,
    output logic        o_req_ready,
    input  wire t_req   i_req,
    output logic        o_rsp_valid,
    input  wire         i_rsp_ready,
    output t_rsp        o_rsp,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire [16:0]  i_cfg_data
);

    localparam int N  = MAX_EXTENTS;
    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);
    localparam int AW = DEF_ADDR_BITS;
    localparam int LW = AW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_FIT  = 3'd2;
    localparam logic [2:0] S_DEL  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]    r_state;
    logic [1:0]    r_mode;
    logic [16:0]   r_cap;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_step;      // cells already passed
    t_req          r_req;
    logic [LW-1:0] r_prev_end;  // first free unit after previous extent
    logic          r_found;
    logic [CW-1:0] r_pick;
    logic [LW-1:0] r_best_start, r_best_size;
    logic          r_rsp_valid;
    t_rsp          r_rsp;

    logic [AW-1:0] w_first [N];
    logic [AW-1:0] w_final [N];
    t_shift        w_ctl;
    logic [IW-1:0] w_pick_idx;

    // effective capacity capped at 2^AW
    logic [LW:0]   w_cap_full;
    logic [LW-1:0] w_cap;
    assign w_cap_full = (LW+1)'(r_cap);
    assign w_cap = (w_cap_full > (LW+1)'(1 << AW)) ? LW'(1 << AW)
                                                   : LW'(w_cap_full);

    logic          w_out_free;
    assign w_out_free  = !r_rsp_valid || i_rsp_ready;
    assign o_req_ready = (r_state == S_IDLE) && w_out_free;
    assign o_cfg_ready = 1'b1;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // early status of an incoming request
    logic [2:0] w_pre_st;
    always_comb begin
        if (i_req.req_type == REQ_ALLOC) begin
            if (r_mode > MODE_WORST)        w_pre_st = ST_BADMODE;
            else if (i_req.length == '0)    w_pre_st = ST_BADLEN;
            else if (r_count >= CW'(N))     w_pre_st = ST_FULL;
            else                            w_pre_st = ST_OK;
        end else if (i_req.req_type == REQ_FREE || i_req.req_type == REQ_COMPACT) begin
            w_pre_st = ST_OK;
        end else begin
            w_pre_st = ST_BADMODE;
        end
    end

    // gap seen at the current step (cell 0 holds extent r_step when in range)
    logic          w_in_tab;
    logic [LW-1:0] w_hi, w_gsize, w_len, w_size;
    logic          w_better;
    assign w_in_tab = r_step < r_count;
    assign w_hi     = w_in_tab ? LW'(w_first[0]) : w_cap;
    assign w_gsize  = (w_hi > r_prev_end) ? w_hi - r_prev_end : '0;
    assign w_len    = LW'(r_req.length);
    assign w_better = (w_gsize >= w_len) && (!r_found ||
                      (r_mode == MODE_BEST  && w_gsize < r_best_size) ||
                      (r_mode == MODE_WORST && w_gsize > r_best_size));
    assign w_size   = LW'(AW'(w_final[0] - w_first[0])) + LW'(1);

    logic w_scan_rot;
    assign w_scan_rot = (r_state == S_SCAN) || (r_state == S_CMP && w_out_free);
    assign w_pick_idx = IW'(r_pick);
    assign w_ctl.rot  = w_scan_rot;
    assign w_ctl.ins  = (r_state == S_FIT) && r_found;
    assign w_ctl.del  = (r_state == S_DEL) && r_found;

    // compact emits a beat per extent, or one beat for an empty table
    logic w_cmp_beat, w_load;
    assign w_cmp_beat = w_in_tab || (r_count == '0 && r_step == '0);
    assign w_load     = w_out_free &&
                        ((r_state == S_OUT) || (r_state == S_CMP && w_cmp_beat));

    // bounds of the extent placed by an allocate
    logic [AW-1:0] w_new_first, w_new_final;
    assign w_new_first = r_best_start[AW-1:0];
    assign w_new_final = AW'(r_best_start + w_len - LW'(1));

    // value re-entering the top of the ring
    logic [AW-1:0] w_top_first, w_top_final;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic [AW-1:0] w_lo_f, w_lo_l, w_hi_f, w_hi_l;
            assign w_lo_f = (g == 0) ? w_first[0] : w_first[(g + N - 1) % N];
            assign w_lo_l = (g == 0) ? w_final[0] : w_final[(g + N - 1) % N];
            // compact rewrites the extent leaving cell 0 into the last cell
            assign w_hi_f = (g == N - 1) ? w_top_first : w_first[(g + 1) % N];
            assign w_hi_l = (g == N - 1) ? w_top_final : w_final[(g + 1) % N];
            cfa_cell #(.AW(AW)) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_at_pick   (w_pick_idx == IW'(g)),
                .i_above     (IW'(g) > w_pick_idx),
                .i_new_first (w_new_first),
                .i_new_final (w_new_final),
                .i_lo_first  (w_lo_f),
                .i_lo_final  (w_lo_l),
                .i_hi_first  (w_hi_f),
                .i_hi_final  (w_hi_l),
                .o_first     (w_first[g]),
                .o_final     (w_final[g])
            );
        end
    endgenerate

    assign w_top_first = (r_state == S_CMP && w_in_tab) ?
                         r_prev_end[AW-1:0] : w_first[0];
    assign w_top_final = (r_state == S_CMP && w_in_tab) ?
                         AW'(r_prev_end + w_size - LW'(1)) : w_final[0];

    // delete match tracking
    logic w_match;
    assign w_match = w_in_tab && (w_first[0] == r_req.address[AW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_FIRST;
            r_cap       <= 17'h10000;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_FIT_MODE) r_mode <= i_cfg_data[1:0];
                else                             r_cap  <= i_cfg_data;
            end
            if (w_load)           r_rsp_valid <= 1'b1;
            else if (i_rsp_ready) r_rsp_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req_valid && o_req_ready) begin
                        r_req        <= i_req;
                        r_step       <= '0;
                        r_prev_end   <= '0;
                        r_found      <= 1'b0;
                        r_pick       <= '0;
                        r_best_start <= '0;
                        r_best_size  <= '0;
                        r_rsp        <= '{w_pre_st, '0, '0, 1'b1};
                        if (w_pre_st != ST_OK)                  r_state <= S_OUT;
                        else if (i_req.req_type == REQ_COMPACT) r_state <= S_CMP;
                        else                                    r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_step <= r_step + CW'(1);
                    if (r_req.req_type == REQ_ALLOC) begin
                        if (r_step <= r_count && w_better &&
                            !(r_found && r_mode == MODE_FIRST)) begin
                            r_found      <= 1'b1;
                            r_pick       <= r_step;
                            r_best_start <= r_prev_end;
                            r_best_size  <= w_gsize;
                        end
                        if (w_in_tab) r_prev_end <= LW'(w_final[0]) + LW'(1);
                    end else if (w_match && !r_found) begin
                        r_found <= 1'b1;
                        r_pick  <= r_step;
                    end
                    if (r_step == CW'(N - 1))
                        r_state <= (r_req.req_type == REQ_ALLOC) ? S_FIT : S_DEL;
                end
                S_FIT: begin
                    r_state <= S_OUT;
                    if (r_found) begin
                        r_count <= r_count + CW'(1);
                        r_rsp.start_address <= 16'(r_best_start);
                    end else begin
                        r_rsp.status <= ST_NOSPACE;
                    end
                end
                S_DEL: begin
                    r_state <= S_OUT;
                    if (r_found) r_count <= r_count - CW'(1);
                    else         r_rsp.status <= ST_NOTFOUND;
                end
                S_CMP: begin
                    if (w_out_free) begin
                        r_step <= r_step + CW'(1);
                        if (w_in_tab) begin
                            r_prev_end <= r_prev_end + w_size;
                            r_rsp <= '{ST_OK, 16'(r_prev_end), 16'(w_first[0]),
                                       (r_step + CW'(1) == r_count)};
                        end else if (r_count == '0 && r_step == '0) begin
                            r_rsp <= '{ST_OK, '0, '0, 1'b1};
                        end
                        if (r_step == CW'(N - 1)) r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (w_out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(N)) else $error("extent count overflow");
    a_busy_no_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_req_ready) else $error("ready while busy");
    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |-> (r_count < CW'(N))) else $error("insert into full table");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !i_rsp_ready) |=> $stable(o_rsp)) else $error("rsp moved");

endmodule
`default_nettype wire

// ----- tb/sv/contiguous_fit_allocator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_fit_allocator_tb
// Self-checking bench: directed table plus random alloc/free/compact and
// unused-type traffic, every result beat compared against an extent-table predictor.
// ----------------------------------------------------------------------------
module contiguous_fit_allocator_tb;
    import cfa_pkg::*;

    localparam int N_EXT = 16;

    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam logic [1:0] MODE_INVALID = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_req_valid;
    logic        o_req_ready;
    t_req        i_req;
    logic        o_rsp_valid;
    logic        i_rsp_ready;
    t_rsp        o_rsp;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [16:0] i_cfg_data;

    contiguous_fit_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    logic [15:0] ext_lo [N_EXT];
    logic [15:0] ext_hi [N_EXT];
    int          ext_num;
    logic [1:0]  pol_mode;
    logic [16:0] pol_cap;

    t_rsp rsp_due[$];
    int   n_bad;
    int   n_rows;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_row;
    t_row rows [$];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("** contiguous_fit_allocator: FAILED **");
        $finish;
    end

    function automatic t_rsp mk_rsp(logic [2:0] st, logic [15:0] sa, logic [15:0] mf, logic lst);
        t_rsp r;
        r.status = st;
        r.start_address = sa;
        r.moved_from = mf;
        r.last = lst;
        return r;
    endfunction

    function automatic t_req mk_req(logic [1:0] rt, logic [16:0] ln, logic [15:0] ad);
        t_req q;
        q.req_type = rt;
        q.length = ln;
        q.address = ad;
        return q;
    endfunction

    function automatic void due_add(t_rsp r);
        rsp_due.insert(rsp_due.size(), r);
    endfunction

    function automatic void add_row(t_req q, bit typed, t_rsp r);
        t_row rw;
        rw.req = q;
        rw.typed = typed;
        rw.rsp = r;
        rows.insert(rows.size(), rw);
    endfunction

    // gap g: space before extent g, or the tail when g == ext_num
    function automatic void gap_span(int g, output longint gs, output longint gz);
        longint lo, hi;
        lo = (g == 0) ? 0 : longint'(ext_hi[g-1]) + 1;
        hi = (g < ext_num) ? longint'(ext_lo[g]) : longint'(pol_cap);
        gs = lo;
        gz = (hi > lo) ? hi - lo : 0;
    endfunction

    task automatic predict_req(t_req q);
        longint gs, gz, bs, bz, len, cur, sz, olds;
        int pick;
        bit found;
        if (q.req_type == REQ_ALLOC) begin
            len = q.length;
            if (pol_mode > MODE_WORST) due_add(mk_rsp(ST_BADMODE, 0, 0, 1));
            else if (len == 0) due_add(mk_rsp(ST_BADLEN, 0, 0, 1));
            else if (ext_num >= N_EXT) due_add(mk_rsp(ST_FULL, 0, 0, 1));
            else begin
                found = 0; pick = 0; bs = 0; bz = 0;
                for (int g = 0; g <= ext_num; g++) begin
                    gap_span(g, gs, gz);
                    if (gz >= len && (!found || (pol_mode == MODE_BEST && gz < bz)
                            || (pol_mode == MODE_WORST && gz > bz))) begin
                        found = 1; pick = g; bs = gs; bz = gz;
                        if (pol_mode == MODE_FIRST) break;
                    end
                end
                if (!found) due_add(mk_rsp(ST_NOSPACE, 0, 0, 1));
                else begin
                    for (int i = ext_num; i > pick; i--) begin
                        ext_lo[i] = ext_lo[i-1];
                        ext_hi[i] = ext_hi[i-1];
                    end
                    ext_lo[pick] = bs[15:0];
                    ext_hi[pick] = 16'(bs + len - 1);
                    ext_num++;
                    due_add(mk_rsp(ST_OK, bs[15:0], 0, 1));
                end
            end
        end else if (q.req_type == REQ_FREE) begin
            found = 0;
            for (int i = 0; i < ext_num && !found; i++) begin
                if (ext_lo[i] == q.address) begin
                    found = 1;
                    for (int j = i; j + 1 < ext_num; j++) begin
                        ext_lo[j] = ext_lo[j+1];
                        ext_hi[j] = ext_hi[j+1];
                    end
                    ext_num--;
                end
            end
            due_add(mk_rsp(found ? ST_OK : ST_NOTFOUND, 0, 0, 1));
        end else if (q.req_type == REQ_COMPACT) begin
            if (ext_num == 0) due_add(mk_rsp(ST_OK, 0, 0, 1));
            cur = 0;
            for (int i = 0; i < ext_num; i++) begin
                olds = ext_lo[i];
                sz = longint'(16'(ext_hi[i] - ext_lo[i])) + 1;
                ext_lo[i] = cur[15:0];
                ext_hi[i] = 16'(cur + sz - 1);
                due_add(mk_rsp(ST_OK, cur[15:0], olds[15:0], i + 1 == ext_num));
                cur += sz;
            end
        end else begin
            due_add(mk_rsp(ST_BADMODE, 0, 0, 1));
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(0, 2);
        if (r < 97) return $urandom_range(3, 20);
        return $urandom_range(40, 150);
    endfunction

    // response side: random stalls, compare against oldest expectation
    initial begin
        t_rsp want;
        i_rsp_ready = 1'b0;
        n_bad = 0;
        @(negedge i_clk);
        forever begin
            i_rsp_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 9) == 0);
            @(posedge i_clk);
            if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
                if (rsp_due.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10) $display("unexpected beat %p", o_rsp);
                end else begin
                    want = rsp_due.pop_front();
                    if (o_rsp !== want) begin
                        n_bad++;
                        if (n_bad <= 10) $display("mismatch exp %p got %p", want, o_rsp);
                    end
                end
            end
            @(negedge i_clk);
            if ($urandom_range(0, 40) == 0) begin
                i_rsp_ready <= 1'b0;
                repeat (1 + pick_gap()) @(negedge i_clk);
            end
        end
    end

    task automatic send_req(t_req q);
        i_req <= q;
        i_req_valid <= 1'b1;
        do @(posedge i_clk); while (!o_req_ready);
        predict_req(q);
        @(negedge i_clk);
        i_req_valid <= 1'b0;
        repeat (1 + pick_gap()) @(negedge i_clk);
    endtask

    task automatic wait_drain();
        int guard;
        guard = 0;
        while (rsp_due.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [16:0] val);
        wait_drain();
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_FIT_MODE) pol_mode = val[1:0];
        else pol_cap = (val > 17'd65536) ? 17'd65536 : val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_req rand_req();
        int r;
        logic [16:0] ln;
        r = $urandom_range(0, 99);
        ln = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(1, 6000));
        if (r < 50) return mk_req(REQ_ALLOC, ln, 16'($urandom));
        if (r < 80) begin
            if (ext_num > 0 && $urandom_range(0, 5) != 0)
                return mk_req(REQ_FREE, 17'($urandom), ext_lo[$urandom_range(0, ext_num-1)]);
            return mk_req(REQ_FREE, 17'($urandom), 16'($urandom));
        end
        if (r < 92) return mk_req(REQ_COMPACT, 17'($urandom), 16'($urandom));
        return mk_req(REQ_UNUSED, 17'($urandom), 16'($urandom));
    endfunction

    initial begin
        t_rsp got;
        i_rst_n = 1'b0;
        i_req_valid = 1'b0;
        i_req = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        ext_num = 0;
        pol_mode = MODE_FIRST;
        pol_cap = 17'd65536;
        for (int i = 0; i < N_EXT; i++) begin
            ext_lo[i] = '0;
            ext_hi[i] = '0;
        end
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table; typed rows follow from reset state and extremes
        add_row(mk_req(REQ_COMPACT, 0, 0), 1, mk_rsp(ST_OK, 0, 0, 1));
        add_row(mk_req(REQ_ALLOC, 0, 0), 1, mk_rsp(ST_BADLEN, 0, 0, 1));
        add_row(mk_req(REQ_FREE, 0, 16'hffff), 1, mk_rsp(ST_NOTFOUND, 0, 0, 1));
        add_row(mk_req(REQ_UNUSED, 17'h1ffff, 16'hffff), 1, mk_rsp(ST_BADMODE, 0, 0, 1));
        add_row(mk_req(REQ_ALLOC, 17'h1ffff, 0), 1, mk_rsp(ST_NOSPACE, 0, 0, 1));
        add_row(mk_req(REQ_ALLOC, 17'd65536, 0), 1, mk_rsp(ST_OK, 0, 0, 1));
        add_row(mk_req(REQ_ALLOC, 1, 0), 1, mk_rsp(ST_NOSPACE, 0, 0, 1));
        add_row(mk_req(REQ_COMPACT, 0, 0), 1, mk_rsp(ST_OK, 0, 0, 1));
        add_row(mk_req(REQ_FREE, 0, 0), 1, mk_rsp(ST_OK, 0, 0, 1));
        for (int i = 0; i < 8; i++)
            add_row(mk_req(REQ_ALLOC, 17'(i + 1), 0), 0, '0);
        add_row(mk_req(REQ_FREE, 0, 16'd1), 0, '0);
        add_row(mk_req(REQ_FREE, 0, 16'd6), 0, '0);
        add_row(mk_req(REQ_COMPACT, 0, 0), 0, '0);
        foreach (rows[k]) begin
            if (rows[k].typed) begin
                wait_drain();
                predict_req(rows[k].req);
                got = rsp_due.pop_back();
                if (got !== rows[k].rsp) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("table row %0d exp %p got %p", k, rows[k].rsp, got);
                end
                // expectation stays queued; drive the request
                due_add(got);
                i_req <= rows[k].req;
                i_req_valid <= 1'b1;
                do @(posedge i_clk); while (!o_req_ready);
                @(negedge i_clk);
                i_req_valid <= 1'b0;
                @(negedge i_clk);
            end else begin
                send_req(rows[k].req);
            end
        end

        // random phases across modes and capacities
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin write_cfg(CFG_FIT_MODE, MODE_BEST); write_cfg(CFG_CAPACITY, 17'd1); end
                1: begin write_cfg(CFG_CAPACITY, 17'h1ffff); end
                2: begin write_cfg(CFG_FIT_MODE, MODE_WORST); write_cfg(CFG_CAPACITY, 17'd40000); end
                3: begin write_cfg(CFG_FIT_MODE, MODE_INVALID); end
                4: begin write_cfg(CFG_FIT_MODE, MODE_FIRST); write_cfg(CFG_CAPACITY, 17'd0); end
                5: begin write_cfg(CFG_FIT_MODE, MODE_BEST); write_cfg(CFG_CAPACITY, 17'd30000); end
                6: begin write_cfg(CFG_FIT_MODE, MODE_WORST); write_cfg(CFG_CAPACITY, 17'd65536); end
                default: begin write_cfg(CFG_FIT_MODE, MODE_FIRST); end
            endcase
            for (int n = 0; n < 60; n++) begin
                send_req(rand_req());
                if (n == 30) wait_drain();
            end
        end

        wait_drain();
        if (n_bad == 0 && rsp_due.size() == 0)
            $display("** contiguous_fit_allocator: PASSED **");
        else
            $display("** contiguous_fit_allocator: FAILED **");
        $finish;
    end

endmodule
